### src/vra_pkg.sv
// ----------------------------------------------------------------------------
// vra_pkg: shared widths, status codes and divider lane type
// Constants and types used by the reflection core and its divider cells.
// ----------------------------------------------------------------------------
package vra_pkg;

  localparam int CW  = 16;          // component width
  localparam int QW  = CW + 1;      // quotient bits, |q| <= 2|v| < 2^(CW+1)
  localparam int DW  = 2 * CW;      // squared axis length
  localparam int RW  = DW + 1;      // partial remainder
  localparam int MW  = 2 * CW + 1;  // magnitude of 2*dot
  localparam int DSW = 2 * CW + 2;  // signed 2*dot
  localparam int PW  = 3 * CW;      // |2*dot| * |a_i|
  localparam int XW  = CW + 3;      // final difference before clamp

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][CW-1:0]     v;
    logic [DW-1:0]          d;
    logic [2:0][RW-1:0]     rem;
    logic [2:0][QW-1:0]     sh;    // dividend bits out, quotient bits in
  } div_lane_t;

endpackage

### src/vra_div_cell.sv
// ----------------------------------------------------------------------------
// vra_div_cell: one restoring division step for three components
// Shifts in one dividend bit per component, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module vra_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  vra_pkg::div_lane_t din,
  output vra_pkg::div_lane_t dout
);

  vra_pkg::div_lane_t dout_r, dout_nxt;
  logic [vra_pkg::RW-1:0] trial [3];
  logic                   fits  [3];

  always_comb begin
    dout_nxt = din;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {din.rem[i][vra_pkg::RW-2:0], din.sh[i][vra_pkg::QW-1]};
      fits[i]  = trial[i] >= {1'b0, din.d};
      dout_nxt.rem[i] = fits[i] ? (trial[i] - {1'b0, din.d}) : trial[i];
      dout_nxt.sh[i]  = {din.sh[i][vra_pkg::QW-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

### src/vector_reflect_about_axis_core.sv
// ----------------------------------------------------------------------------
// vector_reflect_about_axis_core: r = 2(v.a)/|a|^2 * a - v, saturated
// Pipeline: 3 front stages, 17 divider cells and 1 output register lie between
//   the input transaction and result valid.
// Throughput: one transaction per cycle unless out_ready stalls the pipe; the
//   17-cell divider chain yields one quotient bit per cell, one item per stage.
// Reset: rst_n synchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
module vector_reflect_about_axis_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [vra_pkg::CW-1:0] in_vec_x,
  input  logic signed [vra_pkg::CW-1:0] in_vec_y,
  input  logic signed [vra_pkg::CW-1:0] in_vec_z,
  input  logic signed [vra_pkg::CW-1:0] in_axis_x,
  input  logic signed [vra_pkg::CW-1:0] in_axis_y,
  input  logic signed [vra_pkg::CW-1:0] in_axis_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [vra_pkg::CW-1:0] out_refl_x,
  output logic signed [vra_pkg::CW-1:0] out_refl_y,
  output logic signed [vra_pkg::CW-1:0] out_refl_z,
  output logic [1:0]               out_status
);

  localparam int CW  = vra_pkg::CW;
  localparam int QW  = vra_pkg::QW;
  localparam int DW  = vra_pkg::DW;
  localparam int MW  = vra_pkg::MW;
  localparam int DSW = vra_pkg::DSW;
  localparam int PW  = vra_pkg::PW;
  localparam int XW  = vra_pkg::XW;

  // Whole pipe advances together; the output register decouples the sides.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: the six 16x16 products
  logic                          s1_valid_r;
  logic signed [2:0][CW-1:0]     s1_v_r, s1_a_r;
  logic signed [DW-1:0]          s1_va_r [3];
  logic        [DW-1:0]          s1_aa_r [3];
  logic signed [CW-1:0]          in_v [3];
  logic signed [CW-1:0]          in_a [3];

  assign in_v[0] = in_vec_x;
  assign in_v[1] = in_vec_y;
  assign in_v[2] = in_vec_z;
  assign in_a[0] = in_axis_x;
  assign in_a[1] = in_axis_y;
  assign in_a[2] = in_axis_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      for (int i = 0; i < 3; i++) begin
        s1_v_r[i]  <= in_v[i];
        s1_a_r[i]  <= in_a[i];
        s1_va_r[i] <= in_v[i] * in_a[i];
        s1_aa_r[i] <= DW'(DW'(in_a[i]) * DW'(in_a[i]));
      end
    end
  end

  // Stage 2: squared length, 2*dot as sign and magnitude
  logic                      s2_valid_r;
  logic signed [2:0][CW-1:0] s2_v_r, s2_a_r;
  logic [DW-1:0]             s2_len_r;
  logic [MW-1:0]             s2_dmag_r;
  logic                      s2_dneg_r;
  logic signed [DSW-1:0]     dot2;

  assign dot2 = (DSW'(s1_va_r[0]) + DSW'(s1_va_r[1]) + DSW'(s1_va_r[2])) <<< 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      s2_v_r     <= s1_v_r;
      s2_a_r     <= s1_a_r;
      s2_len_r   <= s1_aa_r[0] + s1_aa_r[1] + s1_aa_r[2];
      s2_dneg_r  <= dot2[DSW-1];
      s2_dmag_r  <= dot2[DSW-1] ? MW'(-dot2) : MW'(dot2);
    end
  end

  // Stage 3: numerators |2*dot|*|a_i|, loaded into the divider lane
  vra_pkg::div_lane_t s3_r, s3_nxt;
  logic [CW-1:0] a_mag [3];
  logic [PW-1:0] num   [3];

  always_comb begin
    s3_nxt       = '0;
    s3_nxt.valid = s2_valid_r;
    s3_nxt.zero  = (s2_len_r == '0);
    s3_nxt.d     = s2_len_r;
    s3_nxt.v     = s2_v_r;
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = s2_a_r[i][CW-1] ? CW'(-s2_a_r[i]) : CW'(s2_a_r[i]);
      num[i]   = PW'(s2_dmag_r) * PW'(a_mag[i]);
      s3_nxt.neg[i] = s2_dneg_r ^ s2_a_r[i][CW-1];
      // high part is below the divisor since the quotient fits QW bits
      s3_nxt.rem[i] = vra_pkg::RW'(num[i] >> QW);
      s3_nxt.sh[i]  = num[i][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // Divider chain: one quotient bit per cell
  vra_pkg::div_lane_t chain [QW+1];
  assign chain[0] = s3_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    vra_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // Output stage: sign, subtract v, clamp
  vra_pkg::div_lane_t  dq;
  logic signed [XW-1:0] qs   [3];
  logic signed [XW-1:0] diff [3];
  logic signed [CW-1:0] clip [3];
  logic [2:0]           ovf;
  logic signed [XW-1:0] maxv, minv;

  assign dq   = chain[QW];
  assign maxv = XW'({1'b0, {(CW-1){1'b1}}});
  assign minv = -maxv - XW'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i]   = dq.neg[i] ? -XW'(dq.sh[i]) : XW'(dq.sh[i]);
      diff[i] = qs[i] - XW'($signed(dq.v[i]));
      ovf[i]  = 1'b1;
      if (diff[i] > maxv) begin
        clip[i] = maxv[CW-1:0];
      end else if (diff[i] < minv) begin
        clip[i] = minv[CW-1:0];
      end else begin
        clip[i] = diff[i][CW-1:0];
        ovf[i]  = 1'b0;
      end
    end
  end

  logic                 out_valid_r;
  logic signed [CW-1:0] refl_r [3];
  logic [1:0]           status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dq.valid;
      for (int i = 0; i < 3; i++) begin
        refl_r[i] <= dq.zero ? '0 : clip[i];
      end
      if (dq.zero) begin
        status_r <= vra_pkg::STAT_ZERO;
      end else if (|ovf) begin
        status_r <= vra_pkg::STAT_SAT;
      end else begin
        status_r <= vra_pkg::STAT_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_refl_x = refl_r[0];
  assign out_refl_y = refl_r[1];
  assign out_refl_z = refl_r[2];
  assign out_status = status_r;

  // Zero axis forces all components to zero
  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vra_pkg::STAT_ZERO |->
      out_refl_x == '0 && out_refl_y == '0 && out_refl_z == '0)
    else $error("zero axis result not cleared");

  // Saturation flag means some component sits at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vra_pkg::STAT_SAT |->
      out_refl_x == maxv[CW-1:0] || out_refl_x == minv[CW-1:0] ||
      out_refl_y == maxv[CW-1:0] || out_refl_y == minv[CW-1:0] ||
      out_refl_z == maxv[CW-1:0] || out_refl_z == minv[CW-1:0])
    else $error("saturation flag without clamped component");

  // Status never carries an unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == vra_pkg::STAT_OK || out_status == vra_pkg::STAT_SAT ||
      out_status == vra_pkg::STAT_ZERO)
    else $error("bad status code");

  // A stalled result keeps the front of the pipe frozen
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(s3_r.valid) && $stable(s1_valid_r))
    else $error("pipeline moved during stall");

endmodule

### verif/vector_reflect_about_axis_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_reflect_about_axis_core_tb: self-checking bench for the reflection core
// Drives vector/axis transactions under several idle and stall mixes, predicts
// each reflected vector and status with wide exact arithmetic, and compares
// every output transaction in order against the predicted queue.
// ----------------------------------------------------------------------------
module vector_reflect_about_axis_core_tb;

  localparam int CW = vra_pkg::CW;

  typedef struct {
    logic signed [CW-1:0] rx, ry, rz;
    logic [1:0]           st;
  } refl_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic signed [CW-1:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_refl_x, out_refl_y, out_refl_z;
  logic [1:0] out_status;

  refl_t expected_refl_q[$];
  int    err_cnt = 0;
  int    send_idle_pct = 0;   // sender idle chance, percent
  int    recv_stall_pct = 0;  // receiver stall chance, percent
  int    hold_off_cycles = 0; // long receiver hold-off, counted below

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vector_reflect_about_axis_core dut (.*);

  // Exact reflection: quotient of 2*dot*a_i by |a|^2, truncated toward zero
  // (SV signed division truncates), minus v_i, then clamped.
  function automatic refl_t reflect_vec(logic signed [CW-1:0] vx, vy, vz, ax, ay, az);
    refl_t r;
    longint lsq, dot2;
    logic signed [127:0] num, q, d;
    logic signed [CW-1:0] vv[3];
    longint aa[3];
    bit sat;
    vv[0] = vx; vv[1] = vy; vv[2] = vz;
    aa[0] = ax; aa[1] = ay; aa[2] = az;
    lsq = aa[0] * aa[0] + aa[1] * aa[1] + aa[2] * aa[2];
    if (lsq == 0) begin
      r.rx = '0; r.ry = '0; r.rz = '0; r.st = vra_pkg::STAT_ZERO;
      return r;
    end
    dot2 = 2 * (longint'(vx) * aa[0] + longint'(vy) * aa[1] + longint'(vz) * aa[2]);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num = 128'(signed'(dot2)) * 128'(signed'(aa[i]));
      q = num / 128'(signed'(lsq));
      d = q - 128'(signed'(vv[i]));
      if (d > 128'sd32767) begin
        d = 128'sd32767; sat = 1'b1;
      end else if (d < -128'sd32768) begin
        d = -128'sd32768; sat = 1'b1;
      end
      if (i == 0) r.rx = d[CW-1:0];
      else if (i == 1) r.ry = d[CW-1:0];
      else r.rz = d[CW-1:0];
    end
    r.st = sat ? vra_pkg::STAT_SAT : vra_pkg::STAT_OK;
    return r;
  endfunction

  // Send one transaction; valid stays up across back-to-back items.
  task automatic send_item(logic signed [CW-1:0] vx, vy, vz, ax, ay, az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_vec_x  <= vx; in_vec_y <= vy; in_vec_z <= vz;
    in_axis_x <= ax; in_axis_y <= ay; in_axis_z <= az;
    expected_refl_q.push_back(reflect_vec(vx, vy, vz, ax, ay, az));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CW'($urandom_range(8)) - 16'sd4;
      3: return CW'($urandom_range(8192)) - 16'sd4096; // about +-1.0
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_refl_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(16'sh1000, 0, 0, 16'sh1000, 0, 0);
    send_item(16'sh1000, 0, 0, 0, 16'sh1000, 0);
    send_item(16'sh1234, -16'sh0567, 16'sh0abc, 0, 0, 0);      // zero axis
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0);
    send_item(16'sh7fff, 0, 0, 16'sh0001, 0, 0);
    send_item(16'sh8000, 0, 0, 16'sh0001, 0, 0);               // -min reflects onto itself, no saturation
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_item(16'sh7fff, 16'sh7fff, 0, 16'sh0001, 16'sh0001, 0);
    send_item(16'sh8000, 16'sh8000, 0, 16'sh0001, 16'sh0001, 0);
    send_item(16'sh0003, 16'sh0001, 0, 16'sh0001, 16'sh0001, 16'sh0001);
    send_item(-16'sh0003, 16'sh0001, 0, 16'sh0001, 16'sh0001, 16'sh0001);
    send_item(16'sh0001, 16'sh0002, 16'sh0003, -16'sh0003, 16'sh0002, -16'sh0001);
    send_item(16'sh5555, 16'shaaaa, 16'sh3333, 16'shcccc, 16'sh0f0f, 16'shf0f0);
    send_item(0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh0001);
    drain();
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items)
      send_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    drain();
  endtask

  // Receiver holds off long enough that the pipeline fills and in_ready drops,
  // then the sender waits until every expected result is back.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 80;
    repeat (60)
      send_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    in_valid <= 1'b0;
    while (expected_refl_q.size() != 0) @(posedge clk);
    repeat (20)
      send_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    drain();
  endtask

  // Receiver: ready is driven each edge, with a counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_refl_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected result transaction");
      end else begin
        refl_t e;
        e = expected_refl_q.pop_front();
        if (e.rx !== out_refl_x || e.ry !== out_refl_y || e.rz !== out_refl_z ||
            e.st !== out_status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: exp %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                     e.rx, e.ry, e.rz, e.st, out_refl_x, out_refl_y, out_refl_z,
                     out_status);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200, 0, 0);
    test_random(160, 46, 0);
    test_random(160, 0, 46);
    test_random(160, 31, 31);
    test_backpressure();
    if (err_cnt == 0 && expected_refl_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
